// File: sv/tss_pkg.sv
// Shared constants for the temperature-scaled sigmoid unit.
package tss_pkg;

    localparam int NUM_TEMP_REGS = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int TEMP_W        = 16;
    localparam int LOGIT_W       = 16;
    localparam int POS_W         = 3;
    localparam int PROB_W        = 16;

    localparam logic [TEMP_W-1:0] TEMP_ONE     = 16'd2048;
    localparam logic [TEMP_W-1:0] TEMP_MIN_RAW = 16'd103;
    localparam logic [TEMP_W-1:0] TEMP_MAX_RAW = 16'd40960;

    // Quotient of the temperature divide is |x| in Q.24.
    localparam int U_W = 41;
    localparam logic [U_W-1:0] SAT_LIMIT_Q24 = 41'(12) << 24;

    localparam int TAYLOR_TERMS = 15;
    localparam int NUM_SQUARES  = 4;
    localparam int Y_W          = 30;
    localparam int TERM_W       = 31;
    localparam int SUM_W        = 33;
    localparam int E_W          = 31;
    localparam logic [E_W-1:0] Q30_ONE = 31'h4000_0000;

    // Final divide: 17 quotient bits, 32-bit denominator.
    localparam int Q2_W   = 17;
    localparam int DEN_W  = 32;
    localparam int NUM2_W = 47;

    // Sideband bits carried along the chain.
    localparam int SIDE_W   = 3;
    localparam int SIDE_NEG = 0;
    localparam int SIDE_DEF = 1;
    localparam int SIDE_SAT = 2;

endpackage

// File: sv/tss_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while en is high.
module tss_div_cell
    import tss_pkg::*;
#(
    parameter int DW = 16,
    parameter int LW = 41
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DW-1:0]     in_rem,
    input  logic [LW-1:0]     in_low,
    input  logic [DW-1:0]     in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DW-1:0]     out_rem,
    output logic [LW-1:0]     out_low,
    output logic [DW-1:0]     out_div,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [LW-1:0]     low_reg, low_next;
    logic [DW-1:0]     div_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DW:0]       trial;
    logic              fits;

    always_comb begin
        trial = {in_rem, in_low[LW-1]};
        fits  = trial >= {1'b0, in_div};
        if (fits) begin
            rem_next = DW'(trial - {1'b0, in_div});
        end else begin
            rem_next = trial[DW-1:0];
        end
        low_next = {in_low[LW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// File: sv/tss_taylor_cell.sv
// One Taylor-series cell for exp(-y): term_k = floor(floor(term*y/2^30)/K).
module tss_taylor_cell
    import tss_pkg::*;
#(
    parameter int K = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [Y_W-1:0]          in_y,
    input  logic [TERM_W-1:0]       in_term,
    input  logic signed [SUM_W-1:0] in_sum,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [Y_W-1:0]          out_y,
    output logic [TERM_W-1:0]       out_term,
    output logic signed [SUM_W-1:0] out_sum,
    output logic [SIDE_W-1:0]       out_side
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / K);
    localparam bit          ODD   = (K % 2) == 1;

    // Stage a: product with y.
    logic                    a_valid_reg;
    logic [TERM_W-1:0]       a_p_reg;
    logic [Y_W-1:0]          a_y_reg;
    logic signed [SUM_W-1:0] a_sum_reg;
    logic [SIDE_W-1:0]       a_side_reg;
    // Stage b: reciprocal estimate of p / K.
    logic                    b_valid_reg;
    logic [TERM_W-1:0]       b_p_reg;
    logic [TERM_W-1:0]       b_q_reg;
    logic [Y_W-1:0]          b_y_reg;
    logic signed [SUM_W-1:0] b_sum_reg;
    logic [SIDE_W-1:0]       b_side_reg;
    // Stage c: corrected quotient and accumulation.
    logic                    c_valid_reg;
    logic [TERM_W-1:0]       c_term_reg, c_term_next;
    logic [Y_W-1:0]          c_y_reg;
    logic signed [SUM_W-1:0] c_sum_reg, c_sum_next;
    logic [SIDE_W-1:0]       c_side_reg;

    logic [TERM_W+Y_W-1:0]   prod_a;
    logic [TERM_W+31:0]      prod_b;
    logic [TERM_W+3:0]       qk;
    logic [TERM_W+3:0]       rem_c;

    assign prod_a = (TERM_W+Y_W)'(in_term) * (TERM_W+Y_W)'(in_y);
    assign prod_b = (TERM_W+32)'(a_p_reg) * (TERM_W+32)'(RECIP);

    always_comb begin
        // The estimate is never more than one below the true quotient.
        qk    = (TERM_W+4)'(b_q_reg) * (TERM_W+4)'(K);
        rem_c = (TERM_W+4)'(b_p_reg) - qk;
        if (rem_c >= (TERM_W+4)'(K)) begin
            c_term_next = b_q_reg + 1'b1;
        end else begin
            c_term_next = b_q_reg;
        end
        if (ODD) begin
            c_sum_next = b_sum_reg - $signed({2'b00, c_term_next});
        end else begin
            c_sum_next = b_sum_reg + $signed({2'b00, c_term_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_p_reg    <= prod_a[TERM_W+Y_W-1:30];
            a_y_reg    <= in_y;
            a_sum_reg  <= in_sum;
            a_side_reg <= in_side;
            b_p_reg    <= a_p_reg;
            b_q_reg    <= prod_b[TERM_W+30:31];
            b_y_reg    <= a_y_reg;
            b_sum_reg  <= a_sum_reg;
            b_side_reg <= a_side_reg;
            c_term_reg <= c_term_next;
            c_y_reg    <= b_y_reg;
            c_sum_reg  <= c_sum_next;
            c_side_reg <= b_side_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_y     = c_y_reg;
    assign out_term  = c_term_reg;
    assign out_sum   = c_sum_reg;
    assign out_side  = c_side_reg;

endmodule

// File: sv/tss_square_cell.sv
// One squaring cell in Q.30 with round-half-up.
module tss_square_cell
    import tss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [E_W-1:0]    in_e,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [E_W-1:0]    out_e,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [E_W-1:0]    e_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [2*E_W-1:0]  sq;

    assign sq = (2*E_W)'(in_e) * (2*E_W)'(in_e) + ((2*E_W)'(1) << 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg    <= sq[E_W+29:30];
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_e     = e_reg;
    assign out_side  = side_reg;

endmodule

// File: sv/temperature_scaled_sigmoid_unit.sv
// Top level: temperature select, divide chain, exp chain and sigmoid divide chain.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------
//  s_       | in        | tdata: position[2:0], logit[18:3]
//  m_       | out       | tdata: probability[15:0]; tuser: used_default
//  cfg_     | in        | cfg_index selects temp_pos0..4, cfg_data value
//
// Every stage is a register cell, so one transaction enters per cycle unless the output buffer is full.
// The chain holds 1 select stage, 41 quotient cells, 15 Taylor cells of
// three stages, 4 squaring cells, 17 quotient cells and the output buffer.
// A two-entry output buffer takes results; the chain stalls only when it is full.
// Reset is synchronous; it empties the chain and sets all temperatures to 1.0.
module temperature_scaled_sigmoid_unit
    import tss_pkg::*;
#(
    parameter int NUM_POSITIONS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // position[2:0], logit[18:3], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PROB_W-1:0]    m_tdata,   // probability[15:0]
    output logic [0:0]           m_tuser,   // used_default[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data
);

    localparam int DIV1_N = U_W;

    logic [TEMP_W-1:0] temp_reg [NUM_TEMP_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TEMP_REGS; i++) begin
                temp_reg[i] <= TEMP_ONE;
            end
        end else if (cfg_valid && (32'(cfg_index) < 32'(NUM_TEMP_REGS))) begin
            temp_reg[cfg_index] <= cfg_data;
        end
    end

    // Output buffer and chain enable.
    logic [1:0]          count_reg, count_next;
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [PROB_W:0]     obuf [2];
    logic                en, push, pop;
    logic                res_valid;
    logic [PROB_W-1:0]   res_prob;
    logic                res_def;

    assign en       = count_reg != 2'd2;
    assign s_tready = en;
    assign push     = en && res_valid;
    assign pop      = m_tvalid && m_tready;

    // Input select stage.
    logic [POS_W-1:0]   pos_in;
    logic [LOGIT_W-1:0] logit_in;
    logic [LOGIT_W-1:0] mag_in;
    logic [TEMP_W-1:0]  temp_sel;
    logic               def_sel;
    logic               s0_valid_reg;
    logic [LOGIT_W-1:0] s0_mag_reg;
    logic [TEMP_W-1:0]  s0_temp_reg;
    logic [SIDE_W-1:0]  s0_side_reg;

    assign pos_in   = s_tdata[2:0];
    assign logit_in = s_tdata[18:3];
    assign mag_in   = logit_in[LOGIT_W-1] ? LOGIT_W'(17'h10000 - 17'(logit_in)) : logit_in;

    always_comb begin
        temp_sel = TEMP_ONE;
        def_sel  = 1'b1;
        if ((32'(pos_in) < 32'(NUM_POSITIONS)) && (32'(pos_in) < 32'(NUM_TEMP_REGS))) begin
            if (temp_reg[pos_in] >= TEMP_MIN_RAW && temp_reg[pos_in] <= TEMP_MAX_RAW) begin
                temp_sel = temp_reg[pos_in];
                def_sel  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_mag_reg  <= mag_in;
            s0_temp_reg <= temp_sel;
            s0_side_reg <= {1'b0, def_sel, logit_in[LOGIT_W-1]};
        end
    end

    // Quotient u = |logit| * 2^25 / temperature.
    logic              d1_v    [DIV1_N+1];
    logic [TEMP_W-1:0] d1_rem  [DIV1_N+1];
    logic [U_W-1:0]    d1_low  [DIV1_N+1];
    logic [TEMP_W-1:0] d1_div  [DIV1_N+1];
    logic [SIDE_W-1:0] d1_side [DIV1_N+1];

    assign d1_v[0]    = s0_valid_reg;
    assign d1_rem[0]  = '0;
    assign d1_low[0]  = {s0_mag_reg, 25'd0};
    assign d1_div[0]  = s0_temp_reg;
    assign d1_side[0] = s0_side_reg;

    for (genvar i = 0; i < DIV1_N; i++) begin : g_div1
        tss_div_cell #(.DW(TEMP_W), .LW(U_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(d1_v[i]), .in_rem(d1_rem[i]), .in_low(d1_low[i]),
            .in_div(d1_div[i]), .in_side(d1_side[i]),
            .out_valid(d1_v[i+1]), .out_rem(d1_rem[i+1]), .out_low(d1_low[i+1]),
            .out_div(d1_div[i+1]), .out_side(d1_side[i+1])
        );
    end

    // exp(-|x|/16) from the Taylor series.
    logic                    tc_v    [TAYLOR_TERMS+1];
    logic [Y_W-1:0]          tc_y    [TAYLOR_TERMS+1];
    logic [TERM_W-1:0]       tc_term [TAYLOR_TERMS+1];
    logic signed [SUM_W-1:0] tc_sum  [TAYLOR_TERMS+1];
    logic [SIDE_W-1:0]       tc_side [TAYLOR_TERMS+1];
    logic                    u_sat;

    assign u_sat      = d1_low[DIV1_N] >= SAT_LIMIT_Q24;
    assign tc_v[0]    = d1_v[DIV1_N];
    assign tc_y[0]    = u_sat ? '0 : {d1_low[DIV1_N][27:0], 2'b00};
    assign tc_term[0] = Q30_ONE;
    assign tc_sum[0]  = SUM_W'(Q30_ONE);
    assign tc_side[0] = {u_sat, d1_side[DIV1_N][SIDE_DEF], d1_side[DIV1_N][SIDE_NEG]};

    for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_taylor
        tss_taylor_cell #(.K(i + 1)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(tc_v[i]), .in_y(tc_y[i]), .in_term(tc_term[i]),
            .in_sum(tc_sum[i]), .in_side(tc_side[i]),
            .out_valid(tc_v[i+1]), .out_y(tc_y[i+1]), .out_term(tc_term[i+1]),
            .out_sum(tc_sum[i+1]), .out_side(tc_side[i+1])
        );
    end

    // Four squarings turn exp(-|x|/16) into exp(-|x|).
    logic              sq_v    [NUM_SQUARES+1];
    logic [E_W-1:0]    sq_e    [NUM_SQUARES+1];
    logic [SIDE_W-1:0] sq_side [NUM_SQUARES+1];

    assign sq_v[0]    = tc_v[TAYLOR_TERMS];
    assign sq_e[0]    = tc_sum[TAYLOR_TERMS][SUM_W-1] ? '0 : tc_sum[TAYLOR_TERMS][E_W-1:0];
    assign sq_side[0] = tc_side[TAYLOR_TERMS];

    for (genvar i = 0; i < NUM_SQUARES; i++) begin : g_square
        tss_square_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(sq_v[i]), .in_e(sq_e[i]), .in_side(sq_side[i]),
            .out_valid(sq_v[i+1]), .out_e(sq_e[i+1]), .out_side(sq_side[i+1])
        );
    end

    // Sigmoid as a rounded quotient over 2^30 + e.
    logic [DEN_W-1:0]  den2;
    logic [NUM2_W-1:0] num2;
    logic              d2_v    [Q2_W+1];
    logic [DEN_W-1:0]  d2_rem  [Q2_W+1];
    logic [Q2_W-1:0]   d2_low  [Q2_W+1];
    logic [DEN_W-1:0]  d2_div  [Q2_W+1];
    logic [SIDE_W-1:0] d2_side [Q2_W+1];

    always_comb begin
        den2 = DEN_W'(Q30_ONE) + DEN_W'(sq_e[NUM_SQUARES]);
        if (sq_side[NUM_SQUARES][SIDE_NEG]) begin
            num2 = {sq_e[NUM_SQUARES], 16'd0};
        end else begin
            num2 = NUM2_W'(1) << 46;
        end
        num2 = num2 + NUM2_W'(den2 >> 1);
    end

    assign d2_v[0]    = sq_v[NUM_SQUARES];
    assign d2_rem[0]  = DEN_W'(num2[NUM2_W-1:Q2_W]);
    assign d2_low[0]  = num2[Q2_W-1:0];
    assign d2_div[0]  = den2;
    assign d2_side[0] = sq_side[NUM_SQUARES];

    for (genvar i = 0; i < Q2_W; i++) begin : g_div2
        tss_div_cell #(.DW(DEN_W), .LW(Q2_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(d2_v[i]), .in_rem(d2_rem[i]), .in_low(d2_low[i]),
            .in_div(d2_div[i]), .in_side(d2_side[i]),
            .out_valid(d2_v[i+1]), .out_rem(d2_rem[i+1]), .out_low(d2_low[i+1]),
            .out_div(d2_div[i+1]), .out_side(d2_side[i+1])
        );
    end

    always_comb begin
        res_valid = d2_v[Q2_W];
        res_def   = d2_side[Q2_W][SIDE_DEF];
        if (d2_side[Q2_W][SIDE_SAT]) begin
            res_prob = d2_side[Q2_W][SIDE_NEG] ? '0 : '1;
        end else if (d2_low[Q2_W][Q2_W-1]) begin
            res_prob = '1;
        end else begin
            res_prob = d2_low[Q2_W][PROB_W-1:0];
        end
    end

    // Output buffer.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            obuf[wr_ptr_reg] <= {res_def, res_prob};
        end
    end

    assign m_tvalid   = count_reg != 2'd0;
    assign m_tdata    = obuf[rd_ptr_reg][PROB_W-1:0];
    assign m_tuser[0] = obuf[rd_ptr_reg][PROB_W];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push)
        else $error("result pushed into a full output buffer");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("output buffer count did not follow a push");

endmodule

// File: verif/temperature_scaled_sigmoid_unit_test.sv
// Self-checking testbench for the temperature-scaled sigmoid unit.
`timescale 1ns / 1ps

module temperature_scaled_sigmoid_unit_test;
    import tss_pkg::*;

    localparam int PIPE_SETTLE = 140;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_POS     = 5;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              used_default;
    } prob_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PROB_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TEMP_W-1:0]    cfg_data;

    logic [TEMP_W-1:0] temp_q511 [NUM_TEMP_REGS];
    prob_result_t      pending_probs [$];
    int                error_count;
    int                burst_left;
    int                quiet_cycles = 0;
    int                stall_mode = 0;

    temperature_scaled_sigmoid_unit #(.NUM_POSITIONS(NUM_POS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // exp(-y) in Q.30 by a truncated Taylor series, y given in Q.30 below one.
    function automatic logic [63:0] exp_neg_q30(logic [63:0] y_q30);
        logic signed [63:0] acc;
        logic [63:0]        term;
        acc  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * y_q30) >> 30) / k;
            if (k % 2 == 1) acc = acc - $signed(term);
            else acc = acc + $signed(term);
        end
        if (acc < 0) acc = 0;
        return acc;
    endfunction

    function automatic prob_result_t predict_probability(logic [POS_W-1:0] pos,
                                                         logic [LOGIT_W-1:0] logit);
        prob_result_t r;
        logic         neg;
        logic [63:0]  mag, temp, u, e, den, num, prob;
        neg  = logit[LOGIT_W-1];
        mag  = neg ? (64'h10000 - logit) : logit;
        temp = TEMP_ONE;
        r.used_default = 1'b1;
        if (pos < NUM_POS && pos < NUM_TEMP_REGS) begin
            if (temp_q511[pos] >= TEMP_MIN_RAW && temp_q511[pos] <= TEMP_MAX_RAW) begin
                temp = temp_q511[pos];
                r.used_default = 1'b0;
            end
        end
        u = (mag << 25) / temp;
        if (u >= (64'd12 << 24)) begin
            prob = neg ? 64'd0 : 64'd65535;
        end else begin
            e = exp_neg_q30(u << 2);
            for (int s = 0; s < NUM_SQUARES; s++) e = (e * e + (64'd1 << 29)) >> 30;
            den  = (64'd1 << 30) + e;
            num  = neg ? (e << 16) : (64'd1 << 46);
            prob = (num + den / 2) / den;
            if (prob > 64'd65535) prob = 64'd65535;
        end
        r.probability = prob[PROB_W-1:0];
        return r;
    endfunction

    // Keeps tvalid high across back-to-back transactions inside a burst.
    task automatic send_logit(logic [POS_W-1:0] pos, logic [LOGIT_W-1:0] logit);
        logic accepted;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, logit, pos};
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge aclk);
            accepted = s_tready;
            if (accepted) pending_probs.push_back(predict_probability(pos, logit));
            @(negedge aclk);
        end
        burst_left--;
    endtask

    task automatic end_burst();
        s_tvalid   = 1'b0;
        burst_left = 0;
    endtask

    task automatic drain_pipeline();
        end_burst();
        while (pending_probs.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_temp(logic [CFG_IDX_W-1:0] idx, logic [TEMP_W-1:0] value);
        logic accepted;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        accepted  = 1'b0;
        while (!accepted) begin
            @(posedge aclk);
            accepted = cfg_ready;
            if (accepted && idx < NUM_TEMP_REGS) temp_q511[idx] = value;
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
    endtask

    function automatic logic [TEMP_W-1:0] pick_temperature();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd102;
            2: return 16'd103;
            3: return 16'd40960;
            4: return 16'd40961;
            5: return 16'hFFFF;
            6: return 16'(TEMP_ONE);
            default: return 16'($urandom_range(103, 40960));
        endcase
    endfunction

    function automatic logic [LOGIT_W-1:0] pick_logit();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed(16'($urandom_range(0, 511))) - 16'sd256);
            default: return 16'($signed(16'($urandom_range(0, 8191))) - 16'sd4096);
        endcase
    endfunction

    task automatic test_default_temperature();
        send_logit(3'd0, 16'h0000);
        send_logit(3'd1, 16'h7FFF);
        send_logit(3'd2, 16'h8000);
        send_logit(3'd3, 16'h0001);
        send_logit(3'd4, 16'hFFFF);
        send_logit(3'd5, 16'h0400);
        send_logit(3'd6, 16'hFC00);
        send_logit(3'd7, 16'h1000);
        drain_pipeline();
    endtask

    task automatic test_temperature_bounds();
        write_temp(3'd0, 16'd102);
        write_temp(3'd1, 16'd103);
        write_temp(3'd2, 16'd40960);
        write_temp(3'd3, 16'd40961);
        write_temp(3'd4, 16'd0);
        write_temp(3'd5, 16'd103);
        write_temp(3'd6, 16'hFFFF);
        write_temp(3'd7, 16'd500);
        for (int p = 0; p < 8; p++) send_logit(3'(p), 16'h0C00);
        send_logit(3'd1, 16'h7FFF);
        send_logit(3'd1, 16'h8000);
        send_logit(3'd2, 16'h7FFF);
        send_logit(3'd2, 16'h8000);
        send_logit(3'd2, 16'h0000);
        drain_pipeline();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 8; r++) write_temp(3'(r), pick_temperature());
            for (int n = 0; n < 260; n++) send_logit(3'($urandom_range(0, 7)), pick_logit());
            drain_pipeline();
        end
    endtask

    // Receiver stall pattern: long ready stretches, random stalls, and stall bursts.
    always @(negedge aclk) begin
        if ($urandom_range(0, 127) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge aclk) begin
        prob_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_probs.size() == 0) begin
                $display("%0t: unexpected result probability=%0d used_default=%0d",
                         $time, m_tdata, m_tuser[0]);
                error_count++;
            end else begin
                want = pending_probs.pop_front();
                if (m_tdata !== want.probability) begin
                    $display("%0t: probability expected %0d actual %0d",
                             $time, want.probability, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.used_default) begin
                    $display("%0t: used_default expected %0d actual %0d",
                             $time, want.used_default, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        burst_left   = 0;
        for (int i = 0; i < NUM_TEMP_REGS; i++) temp_q511[i] = TEMP_ONE;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_default_temperature();
        test_temperature_bounds();
        test_random_phases();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
